// File: sv/pfd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pfd_pkg
// Types and constants shared by the pulse-position frame decoder files.
// ---------------------------------------------------------------------------
package pfd_pkg;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_SYNC_GAP  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_PULSE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_PULSE = 2'd2;

    localparam logic [15:0] RST_SYNC_GAP  = 16'd3900;
    localparam logic [15:0] RST_MIN_PULSE = 16'd1000;
    localparam logic [15:0] RST_MAX_PULSE = 16'd2000;

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [7:0] CHAN_IDX_MAX = 8'hFF;

    typedef struct packed {
        logic [15:0] sync_gap_us;
        logic [15:0] min_pulse_us;
        logic [15:0] max_pulse_us;
    } t_cfg;

endpackage
`default_nettype wire

// File: sv/pfd_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pfd_in_if
// Input channel: edge events and channel queries.
// ---------------------------------------------------------------------------
interface pfd_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] edge_time_us;
    logic [2:0]  read_index;

    modport source (output valid, output opcode, output edge_time_us,
                    output read_index, input ready);
    modport sink   (input valid, input opcode, input edge_time_us,
                    input read_index, output ready);
endinterface
`default_nettype wire

// File: sv/pfd_out_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pfd_out_if
// Result channel: channel value, frame channel count and sync flag.
// ---------------------------------------------------------------------------
interface pfd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] channel_value;
    logic [7:0]  channel_count;
    logic        synced;

    modport source (output valid, output channel_value, output channel_count,
                    output synced, input ready);
    modport sink   (input valid, input channel_value, input channel_count,
                    input synced, output ready);
endinterface
`default_nettype wire

// File: sv/pfd_cfg_regs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pfd_cfg_regs
// APB-style register file holding the sync gap and pulse window limits.
// ---------------------------------------------------------------------------
module pfd_cfg_regs import pfd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_gap_us  <= RST_SYNC_GAP;
            r_cfg.min_pulse_us <= RST_MIN_PULSE;
            r_cfg.max_pulse_us <= RST_MAX_PULSE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SYNC_GAP:  r_cfg.sync_gap_us  <= pwdata[15:0];
                REG_MIN_PULSE: r_cfg.min_pulse_us <= pwdata[15:0];
                REG_MAX_PULSE: r_cfg.max_pulse_us <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_SYNC_GAP:  prdata = {16'd0, r_cfg.sync_gap_us};
            REG_MIN_PULSE: prdata = {16'd0, r_cfg.min_pulse_us};
            REG_MAX_PULSE: prdata = {16'd0, r_cfg.max_pulse_us};
            default:       prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/ppm_frame_decoder_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ppm_frame_decoder_unit
// Pulse-position frame decoder: edge timestamps in, channel values out.
// ---------------------------------------------------------------------------
//   channel  | dir | handshake     | payload
//   i_in     | in  | valid/ready   | opcode, edge_time_us, read_index
//   o_out    | out | valid/ready   | channel_value, channel_count, synced
//   apb      | in  | psel/penable  | paddr, pwdata, prdata (pready tied high)
//
// One beat per cycle; the result is in the output register in the cycle after
// acceptance. The single output register sets the rate: a new beat is taken
// whenever it is empty or being drained in the same cycle.
// Synchronous active-low reset clears the state and channel store at once.
// ---------------------------------------------------------------------------
module ppm_frame_decoder_unit import pfd_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    pfd_in_if.sink                  i_in,
    pfd_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam logic [7:0] CHAN_NUM = 8'(CHANNELS);

    t_cfg        cfg;

    logic [31:0] r_last_edge;
    logic        r_edge_seen;
    logic        r_sync_found;
    logic [7:0]  r_cur_chan;
    logic [7:0]  r_frame_cnt;
    logic [15:0] r_store [CHANNELS];

    logic        r_out_valid;
    logic [15:0] r_out_value;
    logic [7:0]  r_out_count;
    logic        r_out_synced;

    logic        accept;
    logic        is_edge;
    logic [31:0] gap;
    logic        is_sync;
    logic        is_pulse;
    logic        in_window;
    logic        store_en;
    logic        n_sync_found;
    logic [7:0]  n_cur_chan;
    logic [7:0]  n_frame_cnt;
    logic [7:0]  rd_idx;
    logic        rd_ok;
    logic [15:0] rd_data;
    logic [15:0] n_out_value;

    pfd_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_edge    = (i_in.opcode == OP_EDGE);

    assign gap       = i_in.edge_time_us - r_last_edge;
    assign is_sync   = r_edge_seen && (gap > {16'd0, cfg.sync_gap_us});
    assign is_pulse  = r_edge_seen && !is_sync && r_sync_found;
    assign in_window = (gap >= {16'd0, cfg.min_pulse_us}) &&
                       (gap <= {16'd0, cfg.max_pulse_us});
    assign store_en  = accept && is_edge && is_pulse && in_window &&
                       (r_cur_chan < CHAN_NUM);

    always_comb begin
        n_sync_found = r_sync_found;
        n_cur_chan   = r_cur_chan;
        n_frame_cnt  = r_frame_cnt;
        if (is_edge) begin
            if (is_sync) begin
                n_sync_found = 1'b1;
                n_frame_cnt  = r_cur_chan;
                n_cur_chan   = '0;
            end else if (is_pulse && r_cur_chan != CHAN_IDX_MAX) begin
                n_cur_chan = r_cur_chan + 8'd1;
            end
        end
    end

    assign rd_idx = {5'd0, i_in.read_index};
    assign rd_ok  = (rd_idx < r_frame_cnt) && (rd_idx < CHAN_NUM);

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (rd_idx == 8'(i)) rd_data = r_store[i];
        end
    end

    assign n_out_value = (!is_edge && rd_ok) ? rd_data : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge  <= '0;
            r_edge_seen  <= 1'b0;
            r_sync_found <= 1'b0;
            r_cur_chan   <= '0;
            r_frame_cnt  <= CHAN_NUM;
        end else if (accept && is_edge) begin
            r_last_edge  <= i_in.edge_time_us;
            r_edge_seen  <= 1'b1;
            r_sync_found <= n_sync_found;
            r_cur_chan   <= n_cur_chan;
            r_frame_cnt  <= n_frame_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CHANNELS; i++) begin
            if (!i_rst_n) begin
                r_store[i] <= '0;
            end else if (store_en && r_cur_chan == 8'(i)) begin
                r_store[i] <= gap[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_value  <= n_out_value;
            r_out_count  <= n_frame_cnt;
            r_out_synced <= n_sync_found;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.channel_value = r_out_value;
    assign o_out.channel_count = r_out_count;
    assign o_out.synced        = r_out_synced;

endmodule
`default_nettype wire

// File: sv/pfd_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pfd_checker
// Port-level checks on the frame decoder, bound to the top level.
// ---------------------------------------------------------------------------
module pfd_checker import pfd_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_opcode,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] out_value,
    input wire logic        out_synced
);

    // beat taken always lands in the output register
    a_accept_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat produced no result");

    // edge beats never return a channel value
    a_edge_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_opcode == OP_EDGE |=> out_value == 16'd0)
        else $error("edge beat returned non-zero value");

    // nothing is stored before the first sync
    a_nosync_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_synced |-> out_value == 16'd0)
        else $error("value reported before sync");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with free output stage");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind ppm_frame_decoder_unit pfd_checker u_pfd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (i_in.valid),
    .in_ready   (i_in.ready),
    .in_opcode  (i_in.opcode),
    .out_valid  (o_out.valid),
    .out_ready  (o_out.ready),
    .out_value  (o_out.channel_value),
    .out_synced (o_out.synced)
);
`default_nettype wire

// File: verif/ppm_frame_decoder_unit_tb.sv
// ---------------------------------------------------------------------------
// ppm_frame_decoder_unit_tb
// Self-checking bench for the pulse-position frame decoder. Edge and query
// beats go in with random idle gaps, and the result port stalls at random.
// Every accepted beat is run through a predictor that keeps its own copy of
// the decoder state. Results are checked in order against the predictor.
// The APB registers are rewritten between phases and read back.
// ---------------------------------------------------------------------------

class pfd_scoreboard #(int NCH = 8);

    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  count;
        logic        synced;
    } t_res;

    logic [15:0] sync_gap;
    logic [15:0] min_pulse;
    logic [15:0] max_pulse;

    logic [31:0] prev_edge;
    bit          have_edge;
    bit          locked;
    logic [7:0]  chan_idx;
    logic [7:0]  frame_count;
    logic [15:0] pulse_store [NCH];

    t_res pending[$];
    int   errors;
    int   n_checked;
    int   n_edge;
    int   n_query;
    int   n_sync;
    int   n_stored;
    bit   saw_sat;

    function new();
        sync_gap    = pfd_pkg::RST_SYNC_GAP;
        min_pulse   = pfd_pkg::RST_MIN_PULSE;
        max_pulse   = pfd_pkg::RST_MAX_PULSE;
        prev_edge   = '0;
        have_edge   = 1'b0;
        locked      = 1'b0;
        chan_idx    = '0;
        frame_count = 8'(NCH);
        foreach (pulse_store[i]) pulse_store[i] = '0;
        errors      = 0;
        n_checked   = 0;
        n_edge      = 0;
        n_query     = 0;
        n_sync      = 0;
        n_stored    = 0;
        saw_sat     = 1'b0;
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void set_reg(logic [pfd_pkg::REG_IDX_W-1:0] idx, logic [15:0] v);
        case (idx)
            pfd_pkg::REG_SYNC_GAP:  sync_gap  = v;
            pfd_pkg::REG_MIN_PULSE: min_pulse = v;
            pfd_pkg::REG_MAX_PULSE: max_pulse = v;
            default: ;
        endcase
    endfunction

    function void note_beat(logic op, logic [31:0] t, logic [2:0] idx);
        t_res        r;
        logic [31:0] gap;
        r = '0;
        if (op == pfd_pkg::OP_EDGE) begin
            n_edge++;
            gap = t - prev_edge;
            if (have_edge) begin
                if (gap > {16'h0, sync_gap}) begin
                    locked      = 1'b1;
                    frame_count = chan_idx;
                    chan_idx    = '0;
                    n_sync++;
                end else if (locked) begin
                    if (gap >= {16'h0, min_pulse} && gap <= {16'h0, max_pulse}
                        && chan_idx < NCH) begin
                        pulse_store[chan_idx] = gap[15:0];
                        n_stored++;
                    end
                    if (chan_idx != pfd_pkg::CHAN_IDX_MAX) chan_idx++;
                    else saw_sat = 1'b1;
                end
            end
            prev_edge = t;
            have_edge = 1'b1;
        end else begin
            n_query++;
            if (idx < frame_count && idx < NCH) r.value = pulse_store[idx];
        end
        r.count  = frame_count;
        r.synced = locked;
        pending.push_back(r);
    endfunction

    function void check_beat(logic [15:0] v, logic [7:0] c, logic s);
        t_res want;
        if (pending.size() == 0) begin
            flag($sformatf("unexpected beat value=%0d count=%0d synced=%0b", v, c, s));
            return;
        end
        want = pending.pop_front();
        n_checked++;
        if (v !== want.value)
            flag($sformatf("channel_value exp %0d got %0d", want.value, v));
        if (c !== want.count)
            flag($sformatf("channel_count exp %0d got %0d", want.count, c));
        if (s !== want.synced)
            flag($sformatf("synced exp %0b got %0b", want.synced, s));
    endfunction

endclass

module ppm_frame_decoder_unit_tb;
    import pfd_pkg::*;

    localparam int N_CHAN = 8;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    pfd_in_if  in_if ();
    pfd_out_if out_if ();

    pfd_scoreboard #(N_CHAN) sb;

    logic [31:0] now_us;
    bit          tx_calm;
    bit          rx_calm;
    int          n_beats;

    ppm_frame_decoder_unit #(.CHANNELS(N_CHAN)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("** ppm_frame_decoder_unit: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready)
                sb.check_beat(out_if.channel_value, out_if.channel_count, out_if.synced);
            if (in_if.valid && in_if.ready)
                sb.note_beat(in_if.opcode, in_if.edge_time_us, in_if.read_index);
        end
    end

    // result-side back-pressure
    initial begin
        int  r;
        int  len;
        bit  val;
        out_if.ready <= 1'b0;
        forever begin
            r = $urandom_range(99, 0);
            if (r < 45) begin
                val = 1'b1; len = $urandom_range(6, 1);
            end else if (r < 55) begin
                val = 1'b1; len = $urandom_range(100, 30);
            end else if (r < 88) begin
                val = 1'b0; len = $urandom_range(3, 1);
            end else if (r < 97) begin
                val = 1'b0; len = $urandom_range(12, 4);
            end else begin
                val = 1'b0; len = $urandom_range(60, 20);
            end
            repeat (len) begin
                @(posedge i_clk);
                out_if.ready <= val | rx_calm;
            end
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(99, 0);
        if (tx_calm || r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic send_beat(logic op, logic [31:0] t, logic [2:0] idx);
        int g;
        g = idle_len();
        if (g > 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.opcode       <= op;
        in_if.edge_time_us <= t;
        in_if.read_index   <= idx;
        do @(posedge i_clk); while (!in_if.ready);
        n_beats++;
    endtask

    task automatic edge_at(logic [31:0] t);
        now_us = t;
        send_beat(OP_EDGE, now_us, 3'($urandom));
    endtask

    task automatic edge_gap(logic [31:0] gap);
        edge_at(now_us + gap);
    endtask

    task automatic query(logic [2:0] idx);
        send_beat(OP_QUERY, $urandom, idx);
    endtask

    task automatic quiesce();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    task automatic apb_xfer(input bit wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [15:0] v, output logic [PDATA_W-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= {16'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] g, logic [15:0] lo, logic [15:0] hi,
                              bit poke_unused);
        logic [REG_IDX_W-1:0] regs [3];
        logic [15:0]          vals [3];
        logic [PDATA_W-1:0]   rd;
        regs = '{REG_SYNC_GAP, REG_MIN_PULSE, REG_MAX_PULSE};
        vals = '{g, lo, hi};
        quiesce();
        foreach (regs[i]) begin
            apb_xfer(1'b1, regs[i], vals[i], rd);
            sb.set_reg(regs[i], vals[i]);
        end
        if (poke_unused) begin
            apb_xfer(1'b1, REG_UNUSED, 16'($urandom), rd);
            sb.set_reg(REG_UNUSED, 16'hFFFF);
        end
        foreach (regs[i]) begin
            apb_xfer(1'b0, regs[i], 16'h0, rd);
            if (rd !== PDATA_W'(vals[i]))
                sb.flag($sformatf("register %0d read exp %0h got %0h", regs[i], vals[i], rd));
        end
    endtask

    function automatic logic [31:0] sync_len();
        if ($urandom_range(19, 0) == 0) return 32'hFFFF_0000 | 32'($urandom);
        return {16'h0, sb.sync_gap} + 32'd1 + $urandom_range(3000, 0);
    endfunction

    function automatic logic [31:0] pulse_len();
        int r;
        r = $urandom_range(99, 0);
        if (sb.min_pulse <= sb.max_pulse && r < 80)
            return $urandom_range(sb.max_pulse, sb.min_pulse);
        if (r < 85) return {16'h0, sb.min_pulse} - 32'd1;
        if (r < 90) return {16'h0, sb.max_pulse} + 32'd1;
        return $urandom_range(70000, 0);
    endfunction

    // mostly whole frames with random content, the rest query bursts, noise and broken frames
    task automatic run_frames(int quota);
        int start;
        int r;
        int nch;
        start = n_beats;
        while (n_beats - start < quota) begin
            r       = $urandom_range(99, 0);
            tx_calm = ($urandom_range(3, 0) == 0);
            if (r < 65) begin
                edge_gap(sync_len());
                nch = ($urandom_range(9, 0) == 0) ? $urandom_range(14, 9)
                                                  : $urandom_range(N_CHAN, 1);
                repeat (nch) begin
                    edge_gap(pulse_len());
                    if ($urandom_range(4, 0) == 0) query(3'($urandom));
                end
            end else if (r < 80) begin
                repeat ($urandom_range(4, 1)) query(3'($urandom));
            end else if (r < 90) begin
                repeat ($urandom_range(3, 1)) edge_gap($urandom);
            end else begin
                edge_gap(sync_len());
                edge_gap({16'h0, sb.sync_gap});
                repeat ($urandom_range(3, 1)) edge_gap($urandom_range(sb.min_pulse, 0));
            end
        end
        tx_calm = 1'b0;
    endtask

    // index runs past 255 and saturates, then the next sync latches it
    task automatic saturate_index();
        edge_gap(sync_len());
        repeat (300) edge_gap($urandom_range(sb.max_pulse, sb.min_pulse));
        edge_gap(sync_len());
        for (int i = 0; i < N_CHAN; i++) query(3'(i));
    endtask

    initial begin
        logic [15:0] lo;
        sb                  = new();
        n_beats             = 0;
        tx_calm             = 1'b0;
        rx_calm             = 1'b0;
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_if.valid        <= 1'b0;
        in_if.opcode       <= OP_EDGE;
        in_if.edge_time_us <= '0;
        in_if.read_index   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset register values
        query(3'd0);
        edge_at(32'd0);
        edge_at(32'd1500);
        edge_at(32'd5400);
        edge_at(32'd9301);
        edge_gap(32'd1000);
        edge_gap(32'd2000);
        edge_gap(32'd999);
        edge_gap(32'd2001);
        edge_gap(32'd1234);
        query(3'd3);
        edge_at(32'hFFFF_FC00);
        edge_gap(32'd1500);
        query(3'd0);
        query(3'd4);
        query(3'd5);
        query(3'd7);
        edge_at(32'hFFFF_FFFF);
        edge_gap(32'd0);

        now_us = $urandom;
        run_frames(150);
        saturate_index();

        set_config(16'd0, 16'd0, 16'hFFFF, 1'b0);
        rx_calm = 1'b1;
        run_frames(80);
        rx_calm = 1'b0;

        set_config(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
        run_frames(150);

        set_config(16'd5000, 16'd3000, 16'd2000, 1'b0);
        run_frames(120);

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        run_frames(60);

        repeat (3) begin
            lo = 16'($urandom);
            set_config(16'($urandom), lo, 16'($urandom_range(16'hFFFF, lo)), 1'b0);
            run_frames(90);
        end

        set_config(RST_SYNC_GAP, RST_MIN_PULSE, RST_MAX_PULSE, 1'b1);
        run_frames(150);

        quiesce();
        repeat (8) @(posedge i_clk);

        $display("%0d edge beats (%0d syncs, %0d pulses stored, index saturated: %0b)",
                 sb.n_edge, sb.n_sync, sb.n_stored, sb.saw_sat);
        $display("%0d query beats; %0d results checked, %0d mismatches",
                 sb.n_query, sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("** ppm_frame_decoder_unit: PASSED **");
        end else begin
            $display("** ppm_frame_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/pfd_pkg.sv
sv/pfd_in_if.sv
sv/pfd_out_if.sv
sv/pfd_cfg_regs.sv
sv/ppm_frame_decoder_unit.sv
sv/pfd_checker.sv
verif/ppm_frame_decoder_unit_tb.sv
